// File: rtl/core/tsop_pkg.sv
// shared types and constants for the tcp syn option parser
package tsop_pkg;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    localparam logic [7:0]  KIND_EOL    = 8'd0;
    localparam logic [7:0]  KIND_NOP    = 8'd1;
    localparam logic [7:0]  KIND_MSS    = 8'd2;
    localparam logic [7:0]  KIND_WSCALE = 8'd3;
    localparam logic [7:0]  KIND_SACKOK = 8'd4;
    localparam logic [7:0]  KIND_TSTAMP = 8'd8;

    localparam logic [7:0]  LEN_MSS     = 8'd4;
    localparam logic [7:0]  LEN_WSCALE  = 8'd3;
    localparam logic [7:0]  LEN_SACKOK  = 8'd2;
    localparam logic [7:0]  LEN_TSTAMP  = 8'd10;
    localparam logic [7:0]  LEN_MIN     = 8'd2;

    localparam logic [7:0]  NOP_BYTE    = 8'h01;
    localparam logic [7:0]  WSCALE_MAX  = 8'd14;
    localparam logic [15:0] MSS_DEFAULT = 16'd1460;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        packet_done;
        logic [15:0] mss;
        logic        wscale_seen;
        logic [3:0]  wscale;
    } result_t;

    // up to two results per accepted request
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// File: rtl/core/tsop_parse.sv
// option byte parse state and per-request result generation
module tsop_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        opt_byte,
    input  logic [5:0]        bytes_left,
    input  logic              first,
    input  logic [15:0]       mss_limit,
    output tsop_pkg::push_t   push
);

    tsop_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  held_kind_reg, held_kind_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  size_reg, size_next;
    logic [5:0]  rem_reg, rem_next;
    logic [15:0] mss_val_reg, mss_val_next;
    logic [7:0]  mss_hi_reg, mss_hi_next;
    logic        seen_reg, seen_next;
    logic [3:0]  scale_reg, scale_next;
    logic        blank_reg, blank_next;

    // state after an optional start of packet
    tsop_pkg::phase_t s_phase;
    logic [7:0]  s_held, s_kind, s_size, s_hi;
    logic [5:0]  s_rem;
    logic [15:0] s_mss;
    logic        s_seen, s_blank;
    logic [3:0]  s_scale;

    logic [7:0]  byte0, byte1;
    logic [1:0]  nres;
    logic        done;
    logic        is_blank;
    logic [5:0]  rem_dec;
    logic [15:0] mss_cand;
    tsop_pkg::result_t res_a, res_b;

    always_comb begin
        s_phase = first ? tsop_pkg::PH_KIND : phase_reg;
        s_held  = first ? 8'd0 : held_kind_reg;
        s_kind  = first ? 8'd0 : kind_reg;
        s_size  = first ? 8'd0 : size_reg;
        s_rem   = first ? 6'd0 : rem_reg;
        s_mss   = first ? mss_limit : mss_val_reg;
        s_hi    = first ? 8'd0 : mss_hi_reg;
        s_seen  = first ? 1'b0 : seen_reg;
        s_scale = first ? 4'd0 : scale_reg;
        s_blank = first ? 1'b0 : blank_reg;
    end

    always_comb begin
        phase_next     = s_phase;
        held_kind_next = s_held;
        kind_next      = s_kind;
        size_next      = s_size;
        rem_next       = s_rem;
        mss_val_next   = s_mss;
        mss_hi_next    = s_hi;
        seen_next      = s_seen;
        scale_next     = s_scale;
        blank_next     = s_blank;
        byte0          = opt_byte;
        byte1          = opt_byte;
        nres           = 2'd1;
        done           = (bytes_left == 6'd1);
        is_blank       = 1'b0;
        rem_dec        = s_rem - 6'd1;
        mss_cand       = {s_hi, opt_byte};

        if (bytes_left == 6'd0) begin
            // empty area: one result, no byte
            byte0 = 8'd0;
            done  = 1'b1;
        end else begin
            unique case (s_phase)
                tsop_pkg::PH_KIND: begin
                    if (opt_byte == tsop_pkg::KIND_EOL) begin
                        phase_next = tsop_pkg::PH_STOP;
                    end else if (opt_byte == tsop_pkg::KIND_NOP) begin
                        phase_next = s_phase;
                    end else if (bytes_left == 6'd1) begin
                        phase_next = tsop_pkg::PH_STOP;
                    end else begin
                        held_kind_next = opt_byte;
                        phase_next     = tsop_pkg::PH_LEN;
                        nres           = 2'd0;
                    end
                end
                tsop_pkg::PH_LEN: begin
                    nres  = 2'd2;
                    byte0 = s_held;
                    if (opt_byte < tsop_pkg::LEN_MIN ||
                        {1'b0, opt_byte} > ({3'd0, bytes_left} + 9'd1)) begin
                        phase_next = tsop_pkg::PH_STOP;
                    end else begin
                        is_blank = (s_held == tsop_pkg::KIND_TSTAMP &&
                                    opt_byte == tsop_pkg::LEN_TSTAMP) ||
                                   (s_held == tsop_pkg::KIND_SACKOK &&
                                    opt_byte == tsop_pkg::LEN_SACKOK);
                        kind_next  = s_held;
                        size_next  = opt_byte;
                        blank_next = is_blank;
                        rem_next   = 6'(opt_byte - tsop_pkg::LEN_MIN);
                        phase_next = (rem_next != 6'd0) ? tsop_pkg::PH_DATA
                                                        : tsop_pkg::PH_KIND;
                        if (is_blank) begin
                            byte0 = tsop_pkg::NOP_BYTE;
                            byte1 = tsop_pkg::NOP_BYTE;
                        end
                    end
                end
                tsop_pkg::PH_DATA: begin
                    if (s_kind == tsop_pkg::KIND_MSS && s_size == tsop_pkg::LEN_MSS) begin
                        if (s_rem == 6'd2) begin
                            mss_hi_next = opt_byte;
                        end else if (s_rem == 6'd1) begin
                            mss_val_next = (mss_cand > mss_limit) ? mss_limit : mss_cand;
                        end
                    end else if (s_kind == tsop_pkg::KIND_WSCALE &&
                                 s_size == tsop_pkg::LEN_WSCALE && s_rem == 6'd1) begin
                        seen_next  = 1'b1;
                        scale_next = (opt_byte > tsop_pkg::WSCALE_MAX) ?
                                     tsop_pkg::WSCALE_MAX[3:0] : opt_byte[3:0];
                    end
                    if (s_blank) begin
                        byte0 = tsop_pkg::NOP_BYTE;
                    end
                    rem_next   = rem_dec;
                    phase_next = (rem_dec == 6'd0) ? tsop_pkg::PH_KIND : tsop_pkg::PH_DATA;
                end
                tsop_pkg::PH_STOP: begin
                    phase_next = s_phase;
                end
                default: begin
                    phase_next = s_phase;
                end
            endcase
        end
    end

    // summary travels only on the packet's final result
    always_comb begin
        res_a.out_byte    = byte0;
        res_a.byte_valid  = (bytes_left != 6'd0);
        res_a.packet_done = (nres == 2'd1) ? done : 1'b0;
        res_a.mss         = res_a.packet_done ? mss_val_next : 16'd0;
        res_a.wscale_seen = res_a.packet_done ? seen_next : 1'b0;
        res_a.wscale      = res_a.packet_done ? scale_next : 4'd0;

        res_b.out_byte    = byte1;
        res_b.byte_valid  = 1'b1;
        res_b.packet_done = done;
        res_b.mss         = done ? mss_val_next : 16'd0;
        res_b.wscale_seen = done ? seen_next : 1'b0;
        res_b.wscale      = done ? scale_next : 4'd0;

        push.count = accept ? nres : 2'd0;
        push.r0    = res_a;
        push.r1    = res_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= tsop_pkg::PH_KIND;
            held_kind_reg <= 8'd0;
            kind_reg      <= 8'd0;
            size_reg      <= 8'd0;
            rem_reg       <= 6'd0;
            mss_val_reg   <= tsop_pkg::MSS_DEFAULT;
            mss_hi_reg    <= 8'd0;
            seen_reg      <= 1'b0;
            scale_reg     <= 4'd0;
            blank_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            held_kind_reg <= held_kind_next;
            kind_reg      <= kind_next;
            size_reg      <= size_next;
            rem_reg       <= rem_next;
            mss_val_reg   <= mss_val_next;
            mss_hi_reg    <= mss_hi_next;
            seen_reg      <= seen_next;
            scale_reg     <= scale_next;
            blank_reg     <= blank_next;
        end
    end

endmodule

// File: rtl/core/tsop_rfifo.sv
// small result queue: two writes, one read per cycle
module tsop_rfifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsop_pkg::push_t     push,
    input  logic                pop,
    output logic                has_room,
    output logic                not_empty,
    output tsop_pkg::result_t   head
);

    tsop_pkg::result_t              mem_reg [tsop_pkg::FIFO_DEPTH];
    logic [tsop_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tsop_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tsop_pkg::FIFO_AW:0]     count_reg, count_next;
    logic [tsop_pkg::FIFO_AW-1:0]   wr_ptr_inc;
    logic                           do_pop;

    assign not_empty  = (count_reg != '0);
    assign has_room   = (count_reg <= (tsop_pkg::FIFO_AW + 1)'(tsop_pkg::FIFO_DEPTH - 2));
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && not_empty;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + tsop_pkg::FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + tsop_pkg::FIFO_AW'(do_pop);
        count_next  = count_reg + (tsop_pkg::FIFO_AW + 1)'(push.count)
                    - (tsop_pkg::FIFO_AW + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/tcp_syn_option_parser.sv
// top level of the tcp syn option parser
// a request's results are in the result queue in the cycle after its acceptance
// throughput: one request per cycle; a length byte yields two results, a held kind none
// input ready drops only when the four-entry result queue has fewer than two free slots
// reset (aresetn low, synchronous): parse state to expect kind, queue empty, mss_limit 1460
module tcp_syn_option_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: mss_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // option byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_opt_byte,
    input  logic [5:0]  s_bytes_left,
    input  logic        s_first,
    // result requests
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_packet_done,
    output logic [15:0] m_mss,
    output logic        m_wscale_seen,
    output logic [3:0]  m_wscale
);

    logic [15:0]        mss_limit_reg;
    logic               s_accept;
    logic               room;
    tsop_pkg::push_t    push;
    tsop_pkg::result_t  head;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mss_limit_reg <= tsop_pkg::MSS_DEFAULT;
        end else if (cfg_valid) begin
            mss_limit_reg <= cfg_data;
        end
    end

    // ready depends only on queue fill, never on the output side this cycle
    assign s_ready  = room;
    assign s_accept = s_valid && s_ready;

    // parse state machine and result formation
    tsop_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .opt_byte   (s_opt_byte),
        .bytes_left (s_bytes_left),
        .first      (s_first),
        .mss_limit  (mss_limit_reg),
        .push       (push)
    );

    // result queue decouples bursts of two results from the one-per-cycle output
    tsop_rfifo u_rfifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_ready),
        .has_room  (room),
        .not_empty (m_valid),
        .head      (head)
    );

    // result fields straight from the queue head register
    assign m_out_byte    = head.out_byte;
    assign m_byte_valid  = head.byte_valid;
    assign m_packet_done = head.packet_done;
    assign m_mss         = head.mss;
    assign m_wscale_seen = head.wscale_seen;
    assign m_wscale      = head.wscale;

endmodule

// File: rtl/core/tsop_checker.sv
// port-level checks for the tcp syn option parser, bound to the top level
module tsop_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_byte_valid,
    input  logic        m_packet_done,
    input  logic [15:0] m_mss,
    input  logic        m_wscale_seen,
    input  logic [3:0]  m_wscale
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // reset empties the result queue
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // summary fields are zero except on the final result
    a_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_packet_done |-> m_mss == 16'd0 && !m_wscale_seen && m_wscale == 4'd0)
        else $error("summary on a non-final result");

    // window scale clamp
    a_wscale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_wscale <= 4'd14)
        else $error("window scale above clamp");

    // a result without a byte is only the empty-area result
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_packet_done && m_out_byte == 8'd0)
        else $error("bad empty-area result");

endmodule

bind tcp_syn_option_parser tsop_checker u_tsop_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_byte_valid  (m_byte_valid),
    .m_packet_done (m_packet_done),
    .m_mss         (m_mss),
    .m_wscale_seen (m_wscale_seen),
    .m_wscale      (m_wscale)
);

// File: tb/tb_tcp_syn_option_parser.sv
// self-checking testbench for the tcp syn option parser: directed table, random option areas
module tb_tcp_syn_option_parser;
    import tsop_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 188;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 8;

    // one row of the directed table; want is only used when pinned is set
    typedef struct packed {
        logic [7:0] opt;
        logic [5:0] left;
        logic       first;
        logic       pinned;
        result_t    want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_opt_byte;
    logic [5:0]  s_bytes_left;
    logic        s_first;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_packet_done;
    logic [15:0] m_mss;
    logic        m_wscale_seen;
    logic [3:0]  m_wscale;

    // typed expectation riding along with the request currently offered
    logic        pin_valid;
    result_t     pin_result;

    // parser shadow state
    logic [15:0] mss_ceiling;
    phase_t      cur_phase;
    logic [7:0]  kind_hold;
    logic [7:0]  opt_kind;
    logic [7:0]  opt_len;
    logic [5:0]  data_left;
    logic [15:0] mss_acc;
    logic [7:0]  mss_msb;
    logic        ws_seen;
    logic [3:0]  ws_shift;
    logic        nop_fill;

    result_t     pending_results[$];
    result_t     oldest;
    stim_row_t   directed_rows[$];
    logic [7:0]  area[$];

    int          error_count;
    int          cycle_count;
    int          items_sent;
    bit          calm;
    bit          long_hold_req;
    int          hold_left;
    int          stall_left;

    tcp_syn_option_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opt_byte    (s_opt_byte),
        .s_bytes_left  (s_bytes_left),
        .s_first       (s_first),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_packet_done (m_packet_done),
        .m_mss         (m_mss),
        .m_wscale_seen (m_wscale_seen),
        .m_wscale      (m_wscale)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------

    // start of a packet: parse state cleared, mss falls back to the ceiling
    function automatic void clear_parse_state();
        cur_phase = PH_KIND;
        kind_hold = '0;
        opt_kind  = '0;
        opt_len   = '0;
        data_left = '0;
        mss_acc   = mss_ceiling;
        mss_msb   = '0;
        ws_seen   = 1'b0;
        ws_shift  = '0;
        nop_fill  = 1'b0;
    endfunction

    // summary fields only travel on the last result of a packet
    function automatic void queue_result(logic [7:0] b, logic bv, logic done);
        result_t r;
        r.out_byte    = b;
        r.byte_valid  = bv;
        r.packet_done = done;
        r.mss         = done ? mss_acc : 16'd0;
        r.wscale_seen = done ? ws_seen : 1'b0;
        r.wscale      = done ? ws_shift : 4'd0;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_option_results(logic [7:0] opt, logic [5:0] left,
                                                   logic first);
        logic       done;
        logic [7:0] idx;
        logic [15:0] word;
        if (first)
            clear_parse_state();
        // empty option area: one summary-only result
        if (left == 6'd0) begin
            queue_result(8'h00, 1'b0, 1'b1);
            return;
        end
        done = (left == 6'd1);
        case (cur_phase)
            PH_KIND: begin
                if (opt == KIND_EOL) begin
                    cur_phase = PH_STOP;
                end else if (opt == KIND_NOP) begin
                    // single byte, passes
                end else if (left == 6'd1) begin
                    // kind with no room for a length: stop parsing
                    cur_phase = PH_STOP;
                end else begin
                    // hold the kind until its length shows up
                    kind_hold = opt;
                    cur_phase = PH_LEN;
                    return;
                end
                queue_result(opt, 1'b1, done);
            end
            PH_LEN: begin
                if (opt < LEN_MIN || opt > ({2'b00, left} + 8'd1)) begin
                    // bad length: both bytes leave untouched, parsing stops
                    cur_phase = PH_STOP;
                    queue_result(kind_hold, 1'b1, 1'b0);
                    queue_result(opt, 1'b1, done);
                end else begin
                    opt_kind  = kind_hold;
                    opt_len   = opt;
                    nop_fill  = (opt_kind == KIND_TSTAMP && opt_len == LEN_TSTAMP) ||
                                (opt_kind == KIND_SACKOK && opt_len == LEN_SACKOK);
                    data_left = 6'(opt_len - 8'd2);
                    cur_phase = (data_left != 6'd0) ? PH_DATA : PH_KIND;
                    queue_result(nop_fill ? NOP_BYTE : opt_kind, 1'b1, 1'b0);
                    queue_result(nop_fill ? NOP_BYTE : opt, 1'b1, done);
                end
            end
            PH_DATA: begin
                idx = opt_len - 8'd2 - {2'b00, data_left};
                if (opt_kind == KIND_MSS && opt_len == LEN_MSS) begin
                    if (idx == 8'd0) begin
                        mss_msb = opt;
                    end else if (idx == 8'd1) begin
                        word    = {mss_msb, opt};
                        mss_acc = (word > mss_ceiling) ? mss_ceiling : word;
                    end
                end else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE &&
                             idx == 8'd0) begin
                    ws_seen  = 1'b1;
                    ws_shift = (opt > WSCALE_MAX) ? WSCALE_MAX[3:0] : opt[3:0];
                end
                data_left = data_left - 6'd1;
                if (data_left == 6'd0)
                    cur_phase = PH_KIND;
                queue_result(nop_fill ? NOP_BYTE : opt, 1'b1, done);
            end
            default: begin
                // stopped: everything passes as is
                queue_result(opt, 1'b1, done);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // monitor: register writes, accepted requests and results, all at the rising edge
    // ------------------------------------------------------------------

    task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                mss_ceiling = cfg_data;
            if (s_valid && s_ready) begin
                predict_option_results(s_opt_byte, s_bytes_left, s_first);
                // directed rows with a hand-written result replace the predicted one
                if (pin_valid)
                    pending_results[pending_results.size() - 1] = pin_result;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected, expected nothing, actual %0h",
                             $time, m_out_byte);
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("out_byte", 16'(oldest.out_byte), 16'(m_out_byte));
                    check_field("byte_valid", 16'(oldest.byte_valid), 16'(m_byte_valid));
                    check_field("packet_done", 16'(oldest.packet_done), 16'(m_packet_done));
                    check_field("mss", oldest.mss, m_mss);
                    check_field("wscale_seen", 16'(oldest.wscale_seen), 16'(m_wscale_seen));
                    check_field("wscale", 16'(oldest.wscale), 16'(m_wscale));
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // idle pattern: mostly short gaps, now and then a long one
    // ------------------------------------------------------------------

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls, plus one long hold-off that backs the block up
    initial begin
        m_ready    = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_item(logic [7:0] opt, logic [5:0] left, logic first,
                             logic pinned, result_t want);
        int g;
        g = calm ? 0 : (($urandom_range(0, 3) == 0) ? gap_len() : 0);
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_opt_byte   = opt;
        s_bytes_left = left;
        s_first      = first;
        pin_valid    = pinned;
        pin_result   = want;
        s_valid      = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic add_row(logic [7:0] opt, logic [5:0] left, logic first,
                           logic pinned, result_t want);
        stim_row_t row;
        row.opt    = opt;
        row.left   = left;
        row.first  = first;
        row.pinned = pinned;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // fill area with one option area, mostly well formed, sometimes junk or cut short
    task automatic build_area();
        int          target;
        int          cut;
        logic [7:0]  k;
        logic [7:0]  len;
        logic [15:0] v16;
        area.delete();
        target = $urandom_range(0, 40);
        if ($urandom_range(0, 99) < 80) begin
            while (area.size() < target) begin
                case ($urandom_range(0, 9))
                    0, 1: area.push_back(KIND_NOP);
                    2: begin
                        v16 = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
                        area.push_back(KIND_MSS);
                        area.push_back(LEN_MSS);
                        area.push_back(v16[15:8]);
                        area.push_back(v16[7:0]);
                    end
                    3: begin
                        area.push_back(KIND_WSCALE);
                        area.push_back(LEN_WSCALE);
                        area.push_back(($urandom_range(0, 3) == 0) ?
                                       8'($urandom_range(15, 255)) : 8'($urandom_range(0, 14)));
                    end
                    4: begin
                        area.push_back(KIND_SACKOK);
                        area.push_back(LEN_SACKOK);
                    end
                    5: begin
                        area.push_back(KIND_TSTAMP);
                        area.push_back(LEN_TSTAMP);
                        repeat (8) area.push_back(8'($urandom));
                    end
                    6: begin
                        // known kind, arbitrary length
                        case ($urandom_range(0, 3))
                            0: k = KIND_MSS;
                            1: k = KIND_WSCALE;
                            2: k = KIND_SACKOK;
                            default: k = KIND_TSTAMP;
                        endcase
                        len = 8'($urandom_range(2, 12));
                        area.push_back(k);
                        area.push_back(len);
                        repeat (len - 8'd2) area.push_back(8'($urandom));
                    end
                    7: begin
                        len = 8'($urandom_range(2, 8));
                        area.push_back(8'($urandom_range(5, 255)));
                        area.push_back(len);
                        repeat (len - 8'd2) area.push_back(8'($urandom));
                    end
                    8: begin
                        // end of list, padding behind it is usually zero
                        area.push_back(KIND_EOL);
                        while (area.size() < target)
                            area.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                    end
                    default: begin
                        // length too short or far past the end
                        area.push_back(8'($urandom_range(2, 255)));
                        area.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 1)) :
                                                              8'($urandom_range(42, 255)));
                    end
                endcase
            end
            while (area.size() > 40)
                void'(area.pop_back());
            if (area.size() > 0 && $urandom_range(0, 4) == 0) begin
                cut = $urandom_range(0, area.size() - 1);
                while (area.size() > cut)
                    void'(area.pop_back());
            end
        end else begin
            repeat (target) area.push_back(8'($urandom));
        end
    endtask

    // a few packets get a wrong byte count or lose their start flag
    task automatic send_area();
        int         n;
        int         mode;
        logic [5:0] left;
        n    = area.size();
        mode = $urandom_range(0, 99);
        if (n == 0) begin
            send_item(8'($urandom), 6'd0, mode >= 4, 1'b0, '0);
            return;
        end
        for (int i = 0; i < n; i++) begin
            left = (mode < 4) ? 6'($urandom) : 6'(n - i);
            send_item(area[i], left, (i == 0) && (mode >= 10), 1'b0, '0);
        end
    endtask

    // register writes only with nothing in flight
    task automatic write_mss_limit(logic [15:0] value);
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        // a held kind leaves nothing behind, so an empty expected queue alone does not show the block idle
        repeat (4) @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        int          phase_end;
        int          hold_mark;
        logic [15:0] new_limit;

        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_opt_byte    = '0;
        s_bytes_left  = '0;
        s_first       = 1'b0;
        pin_valid     = 1'b0;
        pin_result    = '0;
        error_count   = 0;
        items_sent    = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        mss_ceiling   = MSS_DEFAULT;
        clear_parse_state();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty area straight after reset
        add_row(8'h00, 6'd0, 1'b1, 1'b1, result_t'({8'h00, 1'b0, 1'b1, MSS_DEFAULT, 1'b0, 4'd0}));
        // mss of all ones, clamped to the reset ceiling
        add_row(KIND_MSS, 6'd4, 1'b1, 1'b0, '0);
        add_row(LEN_MSS, 6'd3, 1'b0, 1'b0, '0);
        add_row(8'hFF, 6'd2, 1'b0, 1'b0, '0);
        add_row(8'hFF, 6'd1, 1'b0, 1'b1, result_t'({8'hFF, 1'b1, 1'b1, MSS_DEFAULT, 1'b0, 4'd0}));
        // window scale of 255 clamps to 14, then nop, end of list, trailing byte
        add_row(KIND_WSCALE, 6'd6, 1'b1, 1'b0, '0);
        add_row(LEN_WSCALE, 6'd5, 1'b0, 1'b0, '0);
        add_row(8'hFF, 6'd4, 1'b0, 1'b0, '0);
        add_row(KIND_NOP, 6'd3, 1'b0, 1'b0, '0);
        add_row(KIND_EOL, 6'd2, 1'b0, 1'b0, '0);
        add_row(8'hAB, 6'd1, 1'b0, 1'b1, result_t'({8'hAB, 1'b1, 1'b1, MSS_DEFAULT, 1'b1, 4'd14}));
        // sack-permitted and timestamp, both blanked to nops
        add_row(KIND_SACKOK, 6'd12, 1'b1, 1'b0, '0);
        add_row(LEN_SACKOK, 6'd11, 1'b0, 1'b0, '0);
        add_row(KIND_TSTAMP, 6'd10, 1'b0, 1'b0, '0);
        add_row(LEN_TSTAMP, 6'd9, 1'b0, 1'b0, '0);
        add_row(8'h00, 6'd8, 1'b0, 1'b0, '0);
        add_row(8'hFF, 6'd7, 1'b0, 1'b0, '0);
        add_row(8'h55, 6'd6, 1'b0, 1'b0, '0);
        add_row(8'hAA, 6'd5, 1'b0, 1'b0, '0);
        add_row(8'h80, 6'd4, 1'b0, 1'b0, '0);
        add_row(8'h7F, 6'd3, 1'b0, 1'b0, '0);
        add_row(8'h12, 6'd2, 1'b0, 1'b0, '0);
        add_row(8'h34, 6'd1, 1'b0, 1'b1, result_t'({NOP_BYTE, 1'b1, 1'b1, MSS_DEFAULT, 1'b0, 4'd0}));
        // length below the minimum
        add_row(8'h05, 6'd2, 1'b1, 1'b0, '0);
        add_row(8'h01, 6'd1, 1'b0, 1'b0, '0);
        // kind in the last byte
        add_row(8'h07, 6'd1, 1'b1, 1'b1, result_t'({8'h07, 1'b1, 1'b1, MSS_DEFAULT, 1'b0, 4'd0}));

        foreach (directed_rows[i])
            send_item(directed_rows[i].opt, directed_rows[i].left, directed_rows[i].first,
                      directed_rows[i].pinned, directed_rows[i].want);

        // random phases, each after phase 0 under a newly written mss ceiling; phase 0 keeps the reset value
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: new_limit = 16'hFFFF;
                2: new_limit = 16'h0000;
                3: new_limit = 16'($urandom);
                4: new_limit = 16'd536;
                default: new_limit = MSS_DEFAULT;
            endcase
            if (p > 0)
                write_mss_limit(new_limit);
            // one phase runs back to back with no idling on either side
            calm      = (p == 3);
            phase_end = items_sent + ITEMS_PER_PHASE;
            hold_mark = items_sent + 40;
            while (items_sent < phase_end) begin
                if (p == 1 && items_sent >= hold_mark && hold_mark > 0) begin
                    long_hold_req = 1'b1;
                    hold_mark     = 0;
                end
                build_area();
                send_area();
            end
        end
        calm    = 1'b0;
        s_valid = 1'b0;

        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
